FILE: rtl/core/tdau_pkg.sv
package tdau_pkg;

    localparam int AMOUNT_WIDTH = 16;
    localparam int TOT_W        = 17;
    localparam int DVD_W        = TOT_W + AMOUNT_WIDTH;
    localparam int NSTEP        = DVD_W;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);

    typedef logic [TOT_W-1:0]        tot_t;
    typedef logic [DVD_W-1:0]        dvd_t;
    typedef logic [AMOUNT_WIDTH-1:0] amt_t;

    localparam tot_t SEC_PER_DAY  = 17'd86400;
    localparam tot_t SEC_PER_HOUR = 17'd3600;
    localparam tot_t SEC_PER_MIN  = 17'd60;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_INC = 3'd4,
        OP_DEC = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_TIME,
        KIND_DIV,
        KIND_DZ
    } kind_t;

    typedef struct packed {
        logic [2:0]                     req_type;
        logic [4:0]                     a_hour;
        logic [5:0]                     a_minute;
        logic [5:0]                     a_second;
        logic [4:0]                     b_hour;
        logic [5:0]                     b_minute;
        logic [5:0]                     b_second;
        logic signed [AMOUNT_WIDTH-1:0] amount;
    } req_t;

    typedef struct packed {
        logic [4:0]       res_hour;
        logic [5:0]       res_minute;
        logic [5:0]       res_second;
        logic [TOT_W-1:0] quotient;
        logic             div_by_zero;
    } res_t;

    typedef struct packed {
        kind_t kind;
        logic  neg;
        dvd_t  dividend;
        tot_t  divisor;
    } job_t;

endpackage

FILE: rtl/core/tdau_front.sv
module tdau_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  tdau_pkg::req_t   req,
    output logic             req_stall,
    output logic             job_valid,
    output tdau_pkg::job_t   job,
    input  logic             job_ready
);

    logic                 a_vld_reg;
    logic [2:0]           a_op_reg;
    tdau_pkg::tot_t       a_ta_reg;
    tdau_pkg::tot_t       a_tb_reg;
    tdau_pkg::amt_t       a_mag_reg;
    logic                 a_neg_reg;

    logic                 a_en;
    tdau_pkg::tot_t       ta_in;
    tdau_pkg::tot_t       tb_in;
    tdau_pkg::amt_t       amt_u;
    tdau_pkg::amt_t       mag_in;
    logic                 neg_in;
    tdau_pkg::dvd_t       prod;

    assign a_en      = !a_vld_reg || job_ready;
    assign req_stall = !a_en;
    assign job_valid = a_vld_reg;

    // second totals from raw fields
    always_comb
    begin
        ta_in  = tdau_pkg::tot_t'(req.a_hour) * tdau_pkg::SEC_PER_HOUR
               + tdau_pkg::tot_t'(req.a_minute) * tdau_pkg::SEC_PER_MIN
               + tdau_pkg::tot_t'(req.a_second);
        tb_in  = tdau_pkg::tot_t'(req.b_hour) * tdau_pkg::SEC_PER_HOUR
               + tdau_pkg::tot_t'(req.b_minute) * tdau_pkg::SEC_PER_MIN
               + tdau_pkg::tot_t'(req.b_second);
        amt_u  = req.amount;
        neg_in = amt_u[tdau_pkg::AMOUNT_WIDTH-1];
        mag_in = neg_in ? (~amt_u + tdau_pkg::amt_t'(1)) : amt_u;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (a_en)
        begin
            a_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && req_valid)
        begin
            a_op_reg  <= req.req_type;
            a_ta_reg  <= ta_in;
            a_tb_reg  <= tb_in;
            a_mag_reg <= mag_in;
            a_neg_reg <= neg_in;
        end
    end

    assign prod = tdau_pkg::dvd_t'(a_ta_reg) * tdau_pkg::dvd_t'(a_mag_reg);

    // classify and build the dividend and divisor for the back end
    always_comb
    begin
        job.kind     = tdau_pkg::KIND_NONE;
        job.neg      = 1'b0;
        job.dividend = '0;
        job.divisor  = tdau_pkg::SEC_PER_DAY;
        unique case (a_op_reg)
            tdau_pkg::OP_ADD:
            begin
                job.kind     = tdau_pkg::KIND_TIME;
                job.dividend = tdau_pkg::dvd_t'(a_ta_reg) + tdau_pkg::dvd_t'(a_tb_reg);
            end
            tdau_pkg::OP_SUB:
            begin
                job.kind     = tdau_pkg::KIND_TIME;
                job.dividend = tdau_pkg::dvd_t'(a_ta_reg)
                             + tdau_pkg::dvd_t'(tdau_pkg::SEC_PER_DAY)
                             + tdau_pkg::dvd_t'(tdau_pkg::SEC_PER_DAY)
                             - tdau_pkg::dvd_t'(a_tb_reg);
            end
            tdau_pkg::OP_MUL:
            begin
                job.kind     = tdau_pkg::KIND_TIME;
                job.neg      = a_neg_reg;
                job.dividend = prod;
            end
            tdau_pkg::OP_DIV:
            begin
                job.kind     = (a_tb_reg == '0) ? tdau_pkg::KIND_DZ : tdau_pkg::KIND_DIV;
                job.dividend = tdau_pkg::dvd_t'(a_ta_reg);
                job.divisor  = a_tb_reg;
            end
            tdau_pkg::OP_INC:
            begin
                job.kind     = tdau_pkg::KIND_TIME;
                job.dividend = tdau_pkg::dvd_t'(a_ta_reg) + tdau_pkg::dvd_t'(1);
            end
            tdau_pkg::OP_DEC:
            begin
                job.kind     = tdau_pkg::KIND_TIME;
                job.dividend = tdau_pkg::dvd_t'(a_ta_reg)
                             + tdau_pkg::dvd_t'(tdau_pkg::SEC_PER_DAY)
                             - tdau_pkg::dvd_t'(1);
            end
            default:
            begin
                job.kind     = tdau_pkg::KIND_NONE;
            end
        endcase
    end

endmodule

FILE: rtl/core/tdau_queue.sv
module tdau_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  tdau_pkg::job_t push_job,
    output logic           push_ready,
    output logic           pop_valid,
    output tdau_pkg::job_t pop_job,
    input  logic           pop_take
);

    tdau_pkg::job_t              mem_reg [tdau_pkg::QDEPTH];
    logic [tdau_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [tdau_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [tdau_pkg::QPTR_W:0]   count_reg;
    logic [tdau_pkg::QPTR_W:0]   count_next;
    logic                        push;
    logic                        pop;

    assign push_ready = (count_reg != (tdau_pkg::QPTR_W + 1)'(tdau_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_take && pop_valid;
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (tdau_pkg::QPTR_W + 1)'(tdau_pkg::QDEPTH))
        else $error("queue count above depth");

endmodule

FILE: rtl/core/tdau_back.sv
module tdau_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  tdau_pkg::job_t job,
    output logic           job_take,
    output logic           res_valid,
    output tdau_pkg::res_t res,
    input  logic           res_stall
);

    localparam int N = tdau_pkg::NSTEP;

    logic                  st_vld_reg  [0:N];
    tdau_pkg::kind_t       st_kind_reg [0:N];
    logic                  st_neg_reg  [0:N];
    tdau_pkg::tot_t        st_rem_reg  [0:N];
    tdau_pkg::dvd_t        st_dvd_reg  [0:N];
    tdau_pkg::tot_t        st_dvs_reg  [0:N];
    tdau_pkg::tot_t        st_quo_reg  [0:N];

    tdau_pkg::tot_t        st_rem_next [1:N];
    tdau_pkg::tot_t        st_quo_next [1:N];

    logic                  f_vld_reg;
    tdau_pkg::tot_t        f_t_reg;
    tdau_pkg::tot_t        f_quo_reg;
    logic                  f_dz_reg;
    tdau_pkg::tot_t        f_t_next;
    tdau_pkg::tot_t        f_quo_next;

    logic                  h_vld_reg;
    logic [4:0]            h_hour_reg;
    logic [11:0]           h_rem_reg;
    tdau_pkg::tot_t        h_quo_reg;
    logic                  h_dz_reg;
    logic [4:0]            h_hour_next;
    logic [11:0]           h_rem_next;

    logic                  res_vld_reg;
    tdau_pkg::res_t        res_reg;
    logic [5:0]            m_minute_next;
    logic [5:0]            m_second_next;

    logic                  en;

    assign en        = !(res_vld_reg && res_stall);
    assign job_take  = en;
    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    // one restoring step per stage
    always_comb
    begin
        logic [tdau_pkg::TOT_W:0] rs;
        logic                     ge;
        for (int k = 0; k < N; k++)
        begin
            rs = {st_rem_reg[k], st_dvd_reg[k][tdau_pkg::DVD_W-1]};
            ge = (rs >= {1'b0, st_dvs_reg[k]});
            st_rem_next[k+1] = ge ? tdau_pkg::tot_t'(rs - {1'b0, st_dvs_reg[k]})
                                  : rs[tdau_pkg::TOT_W-1:0];
            st_quo_next[k+1] = {st_quo_reg[k][tdau_pkg::TOT_W-2:0], ge};
        end
    end

    // floor wrap for negative products, select fields by kind
    always_comb
    begin
        f_t_next   = '0;
        f_quo_next = '0;
        unique case (st_kind_reg[N])
            tdau_pkg::KIND_TIME:
            begin
                f_t_next = (st_neg_reg[N] && (st_rem_reg[N] != '0))
                         ? tdau_pkg::SEC_PER_DAY - st_rem_reg[N] : st_rem_reg[N];
            end
            tdau_pkg::KIND_DIV:
            begin
                f_quo_next = st_quo_reg[N];
            end
            default:
            begin
                f_t_next = '0;
            end
        endcase
    end

    // hours
    always_comb
    begin
        tdau_pkg::tot_t r;
        tdau_pkg::tot_t step;
        r           = f_t_reg;
        h_hour_next = '0;
        for (int i = 4; i >= 0; i--)
        begin
            step = tdau_pkg::SEC_PER_HOUR << i;
            if (r >= step)
            begin
                r              = r - step;
                h_hour_next[i] = 1'b1;
            end
        end
        h_rem_next = r[11:0];
    end

    // minutes and seconds
    always_comb
    begin
        logic [11:0] r;
        logic [11:0] step;
        r             = h_rem_reg;
        m_minute_next = '0;
        for (int i = 5; i >= 0; i--)
        begin
            step = tdau_pkg::SEC_PER_MIN[11:0] << i;
            if (r >= step)
            begin
                r                = r - step;
                m_minute_next[i] = 1'b1;
            end
        end
        m_second_next = r[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                st_vld_reg[k] <= 1'b0;
            end
            f_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            st_vld_reg[0] <= job_valid;
            for (int k = 1; k <= N; k++)
            begin
                st_vld_reg[k] <= st_vld_reg[k-1];
            end
            f_vld_reg   <= st_vld_reg[N];
            h_vld_reg   <= f_vld_reg;
            res_vld_reg <= h_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_kind_reg[0] <= job.kind;
            st_neg_reg[0]  <= job.neg;
            st_rem_reg[0]  <= '0;
            st_dvd_reg[0]  <= job.dividend;
            st_dvs_reg[0]  <= job.divisor;
            st_quo_reg[0]  <= '0;
            for (int k = 1; k <= N; k++)
            begin
                st_kind_reg[k] <= st_kind_reg[k-1];
                st_neg_reg[k]  <= st_neg_reg[k-1];
                st_rem_reg[k]  <= st_rem_next[k];
                st_dvd_reg[k]  <= st_dvd_reg[k-1] << 1;
                st_dvs_reg[k]  <= st_dvs_reg[k-1];
                st_quo_reg[k]  <= st_quo_next[k];
            end
            f_t_reg   <= f_t_next;
            f_quo_reg <= f_quo_next;
            f_dz_reg  <= (st_kind_reg[N] == tdau_pkg::KIND_DZ);

            h_hour_reg <= h_hour_next;
            h_rem_reg  <= h_rem_next;
            h_quo_reg  <= f_quo_reg;
            h_dz_reg   <= f_dz_reg;

            res_reg.res_hour    <= h_hour_reg;
            res_reg.res_minute  <= m_minute_next;
            res_reg.res_second  <= m_second_next;
            res_reg.quotient    <= h_quo_reg;
            res_reg.div_by_zero <= h_dz_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        st_vld_reg[N] && (st_kind_reg[N] == tdau_pkg::KIND_TIME)
            |-> st_rem_reg[N] < tdau_pkg::SEC_PER_DAY)
        else $error("day remainder out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> (res_reg.res_hour < 5'd24) && (res_reg.res_minute < 6'd60)
            && (res_reg.res_second < 6'd60))
        else $error("result time not normalized");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reg.div_by_zero |-> (res_reg.quotient == '0)
            && (res_reg.res_hour == '0) && (res_reg.res_minute == '0)
            && (res_reg.res_second == '0))
        else $error("divide by zero word carries data");

endmodule

FILE: rtl/core/time_of_day_arithmetic_unit_top.sv
// Time-of-day arithmetic on hh:mm:ss values, modulo 24 hours.
// Request channel: req_valid, req (operation, operands a and b, signed
// amount), req_stall. Result channel: res_valid, res (normalized time,
// quotient, divide-by-zero flag), res_stall. A word moves at a rising edge
// where valid is high and stall is low; every request yields one result,
// in order.
// The front end forms the second totals and the dividend (including the
// amount product), then writes a four-word queue. The back end runs a
// restoring remainder/quotient pipeline of 17 + AMOUNT_WIDTH stages,
// followed by a wrap stage and two stages that split the time into hours,
// minutes and seconds.
// One request is taken every cycle while req_stall is low. While res_stall
// holds with res_valid high, the back pipeline freezes and the front keeps
// taking requests until the queue fills; then req_stall rises.
// Reset clears all valid flags and empties the queue; the data registers are not reset.
module time_of_day_arithmetic_unit_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  tdau_pkg::req_t req,
    output logic           req_stall,
    output logic           res_valid,
    output tdau_pkg::res_t res,
    input  logic           res_stall
);

    logic           fq_valid;
    logic           fq_ready;
    tdau_pkg::job_t fq_job;
    logic           qb_valid;
    logic           qb_take;
    tdau_pkg::job_t qb_job;

    tdau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .job_valid (fq_valid),
        .job       (fq_job),
        .job_ready (fq_ready)
    );

    tdau_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_job   (fq_job),
        .push_ready (fq_ready),
        .pop_valid  (qb_valid),
        .pop_job    (qb_job),
        .pop_take   (qb_take)
    );

    tdau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job       (qb_job),
        .job_take  (qb_take),
        .res_valid (res_valid),
        .res       (res),
        .res_stall (res_stall)
    );

endmodule

FILE: test/tb_time_of_day_arithmetic_unit_top.sv
module tb_time_of_day_arithmetic_unit_top;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam longint DAY_SECS  = 86400;
    localparam longint HOUR_SECS = 3600;
    localparam longint MIN_SECS  = 60;

    localparam int RANDOM_PER_PHASE = 267;
    localparam int DRAIN_CYCLES     = 80;

    class tod_result_board;
        tdau_pkg::res_t pending_results[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        function tdau_pkg::res_t predict_time_op(tdau_pkg::req_t w);
            tdau_pkg::res_t r;
            longint         ta;
            longint         tb;
            longint         ra;
            longint         rb;
            longint         t;
            longint         amt;
            bit             is_time;
            r = '0;
            t = 0;
            is_time = 1'b1;
            ta = longint'(w.a_hour) * HOUR_SECS + longint'(w.a_minute) * MIN_SECS
                 + longint'(w.a_second);
            tb = longint'(w.b_hour) * HOUR_SECS + longint'(w.b_minute) * MIN_SECS
                 + longint'(w.b_second);
            ra = ta % DAY_SECS;
            rb = tb % DAY_SECS;
            case (w.req_type)
                tdau_pkg::OP_ADD: t = (ra + rb) % DAY_SECS;
                tdau_pkg::OP_SUB: t = (ra + DAY_SECS - rb) % DAY_SECS;
                tdau_pkg::OP_MUL:
                begin
                    amt = $signed(w.amount);
                    amt = amt % DAY_SECS;
                    if (amt < 0)
                        amt = amt + DAY_SECS;
                    t = (ra * amt) % DAY_SECS;
                end
                tdau_pkg::OP_DIV:
                begin
                    is_time = 1'b0;
                    if (tb == 0)
                        r.div_by_zero = 1'b1;
                    else
                        r.quotient = tdau_pkg::TOT_W'(ta / tb);
                end
                tdau_pkg::OP_INC: t = (ra + 1) % DAY_SECS;
                tdau_pkg::OP_DEC: t = (ra + DAY_SECS - 1) % DAY_SECS;
                default: is_time = 1'b0;
            endcase
            if (is_time)
            begin
                r.res_hour   = 5'(t / HOUR_SECS);
                r.res_minute = 6'((t / MIN_SECS) % MIN_SECS);
                r.res_second = 6'(t % MIN_SECS);
            end
            return r;
        endfunction

        function void note_request(tdau_pkg::req_t w);
            pending_results.push_back(predict_time_op(w));
        endfunction

        function void compare_field(string name, longint expected, longint actual);
            if (expected != actual)
            begin
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, expected, actual);
                errors++;
            end
        endfunction

        function void check_result(tdau_pkg::res_t got);
            tdau_pkg::res_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("res_hour", want.res_hour, got.res_hour);
            compare_field("res_minute", want.res_minute, got.res_minute);
            compare_field("res_second", want.res_second, got.res_second);
            compare_field("quotient", want.quotient, got.quotient);
            compare_field("div_by_zero", want.div_by_zero, got.div_by_zero);
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    tdau_pkg::req_t req;
    logic           req_stall;
    logic           res_valid;
    tdau_pkg::res_t res;
    logic           res_stall;

    int req_gap_pct;
    int res_hold_pct;

    tod_result_board board;

    time_of_day_arithmetic_unit_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res       (res),
        .res_stall (res_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic tdau_pkg::req_t make_req(logic [2:0] op, int ah, int am, int asec,
                                                int bh, int bm, int bsec, int amt);
        tdau_pkg::req_t w;
        w.req_type = op;
        w.a_hour   = 5'(ah);
        w.a_minute = 6'(am);
        w.a_second = 6'(asec);
        w.b_hour   = 5'(bh);
        w.b_minute = 6'(bm);
        w.b_second = 6'(bsec);
        w.amount   = tdau_pkg::AMOUNT_WIDTH'(amt);
        return w;
    endfunction

    function automatic tdau_pkg::req_t random_req();
        tdau_pkg::req_t w;
        int             pick;
        w = '0;
        if ($urandom_range(99) < 90)
            w.req_type = 3'($urandom_range(5));
        else
            w.req_type = 3'($urandom_range(7));
        if ($urandom_range(9) < 8)
        begin
            w.a_hour   = 5'($urandom_range(23));
            w.a_minute = 6'($urandom_range(59));
            w.a_second = 6'($urandom_range(59));
            w.b_hour   = 5'($urandom_range(23));
            w.b_minute = 6'($urandom_range(59));
            w.b_second = 6'($urandom_range(59));
        end
        else
        begin
            w.a_hour   = 5'($urandom_range(31));
            w.a_minute = 6'($urandom_range(63));
            w.a_second = 6'($urandom_range(63));
            w.b_hour   = 5'($urandom_range(31));
            w.b_minute = 6'($urandom_range(63));
            w.b_second = 6'($urandom_range(63));
        end
        // small divisors give large quotients and hit the zero divisor
        if (w.req_type == tdau_pkg::OP_DIV && $urandom_range(2) == 0)
        begin
            w.b_hour   = '0;
            w.b_minute = '0;
            w.b_second = 6'($urandom_range(5));
        end
        pick = $urandom_range(15);
        case (pick)
            0: w.amount = tdau_pkg::AMOUNT_WIDTH'(-32768);
            1: w.amount = tdau_pkg::AMOUNT_WIDTH'(32767);
            2: w.amount = tdau_pkg::AMOUNT_WIDTH'(-1);
            3: w.amount = '0;
            default: w.amount = tdau_pkg::AMOUNT_WIDTH'($urandom);
        endcase
        return w;
    endfunction

    task automatic send_word(tdau_pkg::req_t w);
        while ($urandom_range(99) < req_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(w);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_word(random_req());
    endtask

    initial
    begin
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                board.check_result(res);
            res_stall <= ($urandom_range(99) < res_hold_pct);
        end
    end

    initial
    begin
        board        = new();
        req_gap_pct  = 28;
        res_hold_pct = 56;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(make_req(tdau_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_req(tdau_pkg::OP_ADD, 23, 59, 59, 23, 59, 59, 0));
        send_word(make_req(tdau_pkg::OP_SUB, 0, 0, 0, 0, 0, 1, 0));
        send_word(make_req(tdau_pkg::OP_SUB, 12, 34, 56, 23, 59, 59, 0));
        send_word(make_req(tdau_pkg::OP_MUL, 23, 59, 59, 0, 0, 0, -32768));
        send_word(make_req(tdau_pkg::OP_MUL, 23, 59, 59, 0, 0, 0, 32767));
        send_word(make_req(tdau_pkg::OP_MUL, 1, 0, 0, 0, 0, 0, -1));
        send_word(make_req(tdau_pkg::OP_MUL, 12, 0, 0, 0, 0, 0, 0));
        send_word(make_req(tdau_pkg::OP_DIV, 23, 59, 59, 0, 0, 1, 0));
        send_word(make_req(tdau_pkg::OP_DIV, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_req(tdau_pkg::OP_DIV, 12, 0, 0, 0, 0, 0, 0));
        send_word(make_req(tdau_pkg::OP_DIV, 31, 63, 63, 0, 0, 1, 0));
        send_word(make_req(tdau_pkg::OP_DIV, 1, 2, 3, 23, 59, 59, 0));
        send_word(make_req(tdau_pkg::OP_INC, 23, 59, 59, 0, 0, 0, 0));
        send_word(make_req(tdau_pkg::OP_INC, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_req(tdau_pkg::OP_DEC, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_req(tdau_pkg::OP_DEC, 23, 59, 59, 0, 0, 0, 0));
        send_word(make_req(tdau_pkg::OP_ADD, 31, 63, 63, 31, 63, 63, 0));
        send_word(make_req(tdau_pkg::OP_SUB, 0, 0, 0, 31, 63, 63, 0));
        send_word(make_req(tdau_pkg::OP_MUL, 31, 63, 63, 0, 0, 0, -32768));
        send_word(make_req(tdau_pkg::OP_INC, 31, 63, 63, 0, 0, 0, 0));
        send_word(make_req(OP_RSVD6, 31, 63, 63, 31, 63, 63, -1));
        send_word(make_req(OP_RSVD7, 0, 0, 0, 0, 0, 0, 0));

        send_random(RANDOM_PER_PHASE);
        req_gap_pct  = 56;
        res_hold_pct = 28;
        send_random(RANDOM_PER_PHASE);
        req_gap_pct  = 0;
        res_hold_pct = 0;
        send_random(RANDOM_PER_PHASE);
        req_valid <= 1'b0;

        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: time_of_day_arithmetic_unit_top.f
rtl/core/tdau_pkg.sv
rtl/core/tdau_front.sv
rtl/core/tdau_queue.sv
rtl/core/tdau_back.sv
rtl/core/time_of_day_arithmetic_unit_top.sv
test/tb_time_of_day_arithmetic_unit_top.sv
